// ===== hw/rtl/packet_round_robin_output_merger_assert.svh =====
// Assertion macros for the output merger.
`ifndef PACKET_ROUND_ROBIN_OUTPUT_MERGER_ASSERT_SVH
`define PACKET_ROUND_ROBIN_OUTPUT_MERGER_ASSERT_SVH
`ifndef SYNTHESIS
`define PROM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("output merger check failed");
`define PROM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("output merger check failed");
`else
`define PROM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PROM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/prom_pkg.sv =====
`timescale 1ns / 1ps
package prom_pkg;

   localparam int DATA_W = 32;
   localparam int CHAN_W = 3;
   localparam int PORT_W = 2;
   localparam int DROP_W = 2;
   localparam int CFG_W  = 4;

   localparam int DEF_PORTS        = 4;
   localparam int DEF_MAX_VCS      = 8;
   localparam int DEF_QUEUE_DEPTH  = 16;
   localparam int DEF_PAYLOAD_BITS = 32;

   localparam int CMD_FIFO_DEPTH = 2;
   localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

   localparam logic [CFG_W-1:0] ACTIVE_VCS_RESET = 4'd8;

   // dropped flag bit positions
   localparam int DROP_A = 0;
   localparam int DROP_B = 1;

   localparam logic SUBNET_A = 1'b0;
   localparam logic SUBNET_B = 1'b1;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic              port_ok;
      logic              a_ok;
      logic [CHAN_W-1:0] a_chan;
      logic              a_tail;
      logic [DATA_W-1:0] a_payload;
      logic              b_ok;
      logic [CHAN_W-1:0] b_chan;
      logic              b_tail;
      logic [DATA_W-1:0] b_payload;
      logic [DROP_W-1:0] dropped;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_beat_type;

   typedef struct packed {
      logic              out_valid;
      logic              out_subnet;
      logic [CHAN_W-1:0] out_chan;
      logic              out_tail;
      logic [DATA_W-1:0] out_payload;
      logic [DROP_W-1:0] dropped;
   } rsp_type;

endpackage

// ===== hw/rtl/prom_channels.sv =====
`timescale 1ns / 1ps
interface prom_req_if;
   import prom_pkg::*;
   logic              valid;
   logic              ready;
   logic [PORT_W-1:0] port;
   logic              a_valid;
   logic [CHAN_W-1:0] a_chan;
   logic              a_tail;
   logic [DATA_W-1:0] a_payload;
   logic              b_valid;
   logic [CHAN_W-1:0] b_chan;
   logic              b_tail;
   logic [DATA_W-1:0] b_payload;
   modport source (output valid, port, a_valid, a_chan, a_tail, a_payload,
                   b_valid, b_chan, b_tail, b_payload, input ready);
   modport sink (input valid, port, a_valid, a_chan, a_tail, a_payload,
                 b_valid, b_chan, b_tail, b_payload, output ready);
endinterface

interface prom_rsp_if;
   import prom_pkg::*;
   logic              valid;
   logic              ready;
   logic              out_valid;
   logic              out_subnet;
   logic [CHAN_W-1:0] out_chan;
   logic              out_tail;
   logic [DATA_W-1:0] out_payload;
   logic [DROP_W-1:0] dropped;
   modport source (output valid, out_valid, out_subnet, out_chan, out_tail,
                   out_payload, dropped, input ready);
   modport sink (input valid, out_valid, out_subnet, out_chan, out_tail,
                 out_payload, dropped, output ready);
endinterface

interface prom_csr_if;
   import prom_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/prom_front.sv =====
`timescale 1ns / 1ps
module prom_front #(
   parameter int PORTS   = prom_pkg::DEF_PORTS,
   parameter int MAX_VCS = prom_pkg::DEF_MAX_VCS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [$clog2(MAX_VCS+1)-1:0] nvc,
   prom_req_if.sink                     req_ch,
   output prom_pkg::cmd_beat_type       push_beat,
   input  logic                         push_ready,
   output logic                         busy
);
   import prom_pkg::*;

   logic    vld_ff, vld_in;
   cmd_type cmd_ff, cmd_in;
   cmd_type cls;
   logic    port_ok, a_act, b_act, take;

   // classify: port range and active channel check
   always_comb begin
      port_ok = 32'(req_ch.port) < 32'(PORTS);
      a_act   = 32'(req_ch.a_chan) < 32'(nvc);
      b_act   = 32'(req_ch.b_chan) < 32'(nvc);
      cls.port      = req_ch.port;
      cls.port_ok   = port_ok;
      cls.a_ok      = req_ch.a_valid && port_ok && a_act;
      cls.a_chan    = req_ch.a_chan;
      cls.a_tail    = req_ch.a_tail;
      cls.a_payload = req_ch.a_payload;
      cls.b_ok      = req_ch.b_valid && port_ok && b_act;
      cls.b_chan    = req_ch.b_chan;
      cls.b_tail    = req_ch.b_tail;
      cls.b_payload = req_ch.b_payload;
      cls.dropped   = '0;
      cls.dropped[DROP_A] = req_ch.a_valid && !(port_ok && a_act);
      cls.dropped[DROP_B] = req_ch.b_valid && !(port_ok && b_act);
   end

   assign req_ch.ready = !vld_ff || push_ready;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      vld_in = vld_ff;
      cmd_in = cmd_ff;
      if (take) begin
         vld_in = 1'b1;
         cmd_in = cls;
      end else if (push_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assign push_beat.valid = vld_ff;
   assign push_beat.cmd   = cmd_ff;
   assign busy            = vld_ff;

endmodule

// ===== hw/rtl/prom_cmd_fifo.sv =====
`timescale 1ns / 1ps
module prom_cmd_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  prom_pkg::cmd_beat_type              push_beat,
   output logic                                push_ready,
   output prom_pkg::cmd_beat_type              pop_beat,
   input  logic                                pop,
   output logic [prom_pkg::CMD_CNT_W-1:0]      level
);
   import prom_pkg::*;

   localparam int QIDX_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;

   cmd_type               mem_ff [CMD_FIFO_DEPTH];
   logic [QIDX_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CMD_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign push_ready   = cnt_ff != CMD_CNT_W'(CMD_FIFO_DEPTH);
   assign do_push      = push_beat.valid && push_ready;
   assign do_pop       = pop && (cnt_ff != '0);
   assign pop_beat.valid = cnt_ff != '0;
   assign pop_beat.cmd   = mem_ff[rd_ff];
   assign level        = cnt_ff;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == QIDX_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QIDX_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_beat.cmd;
      end
   end

endmodule

// ===== hw/rtl/prom_back.sv =====
`timescale 1ns / 1ps
module prom_back #(
   parameter int PORTS        = prom_pkg::DEF_PORTS,
   parameter int MAX_VCS      = prom_pkg::DEF_MAX_VCS,
   parameter int QUEUE_DEPTH  = prom_pkg::DEF_QUEUE_DEPTH,
   parameter int PAYLOAD_BITS = prom_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [$clog2(MAX_VCS+1)-1:0] nvc,
   input  prom_pkg::cmd_beat_type       pop_beat,
   output logic                         pop,
   prom_rsp_if.source                   rsp_ch
);
   import prom_pkg::*;

   localparam int PIDX_W  = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int VC_W    = (MAX_VCS > 1) ? $clog2(MAX_VCS) : 1;
   localparam int NVC_W   = $clog2(MAX_VCS + 1);
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int NQ      = 2 * MAX_VCS;
   localparam int POS_W   = VC_W + 1;
   localparam int ENTRY_W = PAYLOAD_BITS + 1;

   // per-port state: FIFO counts and pointers plus the round-robin position
   typedef struct packed {
      logic [1:0][MAX_VCS-1:0][CNT_W-1:0] cnt;
      logic [1:0][MAX_VCS-1:0][PTR_W-1:0] rd;
      logic [1:0][MAX_VCS-1:0][PTR_W-1:0] wr;
      logic                               cur_sub;
      logic [VC_W-1:0]                    cur_chan;
   } row_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PUSH = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_POP  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   row_type            row_mem [PORTS];
   row_type            row_rd_ff;
   logic               row_hit_ff;
   logic [PORTS-1:0]   row_vld_ff;
   row_type            row_ff, row_in;
   logic               sub_ff, sub_in;
   logic [VC_W-1:0]    chan_ff, chan_in;
   logic               found_ff, found_in;
   logic [DROP_W-1:0]  drop_ff, drop_in;
   logic [ENTRY_W-1:0] store0_mem [PORTS][MAX_VCS][QUEUE_DEPTH];
   logic [ENTRY_W-1:0] store1_mem [PORTS][MAX_VCS][QUEUE_DEPTH];
   logic [ENTRY_W-1:0] ent0_rd_ff, ent1_rd_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_vld_ff, rsp_vld_in;

   logic [PIDX_W-1:0]  pidx_head, pidx;
   logic [VC_W-1:0]    ac, bc;
   row_type            row_base, row_push, row_scan, row_pop;
   logic               a_full, b_full, a_do, b_do;
   logic [DROP_W-1:0]  drop_push;
   logic               os;
   logic [VC_W-1:0]    oc;
   logic [POS_W-1:0]   start, hi_pos, lo_pos, sel;
   logic               hi_hit, lo_hit, found;
   logic [NQ-1:0]      ne;
   logic               s_sel;
   logic [VC_W-1:0]    c_sel;
   logic [ENTRY_W-1:0] ent;
   logic               tail;
   logic [POS_W-1:0]   nxt;
   logic               out_free, load;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // step the scan position: other subnet first, then the next channel
   function automatic logic [POS_W-1:0] next_pos(input logic s, input logic [VC_W-1:0] c,
                                                 input logic [NVC_W-1:0] n);
      logic [NVC_W:0] inc;
      inc = (NVC_W + 1)'(c) + 1'b1;
      if (s == SUBNET_A) begin
         return {c, SUBNET_B};
      end else if (inc >= {1'b0, n}) begin
         return {{VC_W{1'b0}}, SUBNET_A};
      end else begin
         return {VC_W'(inc), SUBNET_A};
      end
   endfunction

   assign pidx_head = pop_beat.cmd.port_ok ? PIDX_W'(pop_beat.cmd.port) : '0;
   assign pidx      = cmd_ff.port_ok ? PIDX_W'(cmd_ff.port) : '0;
   assign ac        = VC_W'(cmd_ff.a_chan);
   assign bc        = VC_W'(cmd_ff.b_chan);
   assign pop       = (state_ff == ST_IDLE) && pop_beat.valid;
   assign out_free  = !rsp_vld_ff || rsp_ch.ready;
   assign load      = (state_ff == ST_POP) && out_free;

   // enqueue: one flit per subnet, each into its own store
   always_comb begin
      row_base = row_hit_ff ? row_rd_ff : '0;
      a_full   = row_base.cnt[SUBNET_A][ac] >= CNT_W'(QUEUE_DEPTH);
      b_full   = row_base.cnt[SUBNET_B][bc] >= CNT_W'(QUEUE_DEPTH);
      a_do     = cmd_ff.a_ok && !a_full;
      b_do     = cmd_ff.b_ok && !b_full;
      row_push = row_base;
      if (a_do) begin
         row_push.cnt[SUBNET_A][ac] = row_base.cnt[SUBNET_A][ac] + 1'b1;
         row_push.wr[SUBNET_A][ac]  = ptr_inc(row_base.wr[SUBNET_A][ac]);
      end
      if (b_do) begin
         row_push.cnt[SUBNET_B][bc] = row_base.cnt[SUBNET_B][bc] + 1'b1;
         row_push.wr[SUBNET_B][bc]  = ptr_inc(row_base.wr[SUBNET_B][bc]);
      end
      drop_push = cmd_ff.dropped;
      drop_push[DROP_A] = cmd_ff.dropped[DROP_A] || (cmd_ff.a_ok && a_full);
      drop_push[DROP_B] = cmd_ff.dropped[DROP_B] || (cmd_ff.b_ok && b_full);
   end

   // rotating priority search over positions {chan, subnet}
   always_comb begin
      os = row_ff.cur_sub;
      oc = row_ff.cur_chan;
      if (32'(row_ff.cur_chan) >= 32'(nvc)) begin
         os = SUBNET_A;
         oc = '0;
      end
      start = {oc, os};
      for (int c = 0; c < MAX_VCS; c++) begin
         for (int s = 0; s < 2; s++) begin
            ne[2*c + s] = (row_ff.cnt[s][c] != '0) && (32'(c) < 32'(nvc));
         end
      end
      hi_hit = 1'b0;
      lo_hit = 1'b0;
      hi_pos = '0;
      lo_pos = '0;
      for (int i = NQ - 1; i >= 0; i--) begin
         if (ne[i]) begin
            lo_hit = 1'b1;
            lo_pos = POS_W'(i);
            if (POS_W'(i) >= start) begin
               hi_hit = 1'b1;
               hi_pos = POS_W'(i);
            end
         end
      end
      found = cmd_ff.port_ok && (hi_hit || lo_hit);
      sel   = found ? (hi_hit ? hi_pos : lo_pos) : start;
      s_sel = sel[0];
      c_sel = sel[POS_W-1:1];
      row_scan          = row_ff;
      row_scan.cur_sub  = s_sel;
      row_scan.cur_chan = c_sel;
      if (found) begin
         row_scan.cnt[s_sel][c_sel] = row_ff.cnt[s_sel][c_sel] - 1'b1;
         row_scan.rd[s_sel][c_sel]  = ptr_inc(row_ff.rd[s_sel][c_sel]);
      end
   end

   // delivery: a tail flit moves the pointer on
   always_comb begin
      ent  = (sub_ff == SUBNET_B) ? ent1_rd_ff : ent0_rd_ff;
      tail = found_ff && ent[PAYLOAD_BITS];
      nxt  = next_pos(sub_ff, chan_ff, nvc);
      row_pop = row_ff;
      if (tail) begin
         row_pop.cur_sub  = nxt[0];
         row_pop.cur_chan = nxt[POS_W-1:1];
      end
      rsp_in.out_valid   = found_ff;
      rsp_in.out_subnet  = sub_ff;
      rsp_in.out_chan    = found_ff ? CHAN_W'(chan_ff) : '0;
      rsp_in.out_tail    = tail;
      rsp_in.out_payload = found_ff ? DATA_W'(ent[PAYLOAD_BITS-1:0]) : '0;
      rsp_in.dropped     = drop_ff;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      row_in     = row_ff;
      sub_in     = sub_ff;
      chan_in    = chan_ff;
      found_in   = found_ff;
      drop_in    = drop_ff;
      rsp_vld_in = rsp_vld_ff;
      if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (pop_beat.valid) begin
               cmd_in   = pop_beat.cmd;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            row_in   = row_push;
            drop_in  = drop_push;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            row_in   = row_scan;
            sub_in   = cmd_ff.port_ok ? s_sel : SUBNET_A;
            chan_in  = c_sel;
            found_in = found;
            state_in = ST_POP;
         end
         ST_POP: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
         row_vld_ff <= '0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         if (load && cmd_ff.port_ok) begin
            row_vld_ff[pidx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      row_ff   <= row_in;
      sub_ff   <= sub_in;
      chan_ff  <= chan_in;
      found_ff <= found_in;
      drop_ff  <= drop_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // port state memory: read one row, write it back at the end of the item
   always_ff @(posedge clock) begin
      if (pop) begin
         row_rd_ff  <= row_mem[pidx_head];
         row_hit_ff <= row_vld_ff[pidx_head];
      end
      if (load && cmd_ff.port_ok) begin
         row_mem[pidx] <= row_pop;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_PUSH) && a_do) begin
         store0_mem[pidx][ac][row_base.wr[SUBNET_A][ac]] <=
            {cmd_ff.a_tail, PAYLOAD_BITS'(cmd_ff.a_payload)};
      end
      if (state_ff == ST_SCAN) begin
         ent0_rd_ff <= store0_mem[pidx][c_sel][row_ff.rd[SUBNET_A][c_sel]];
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_PUSH) && b_do) begin
         store1_mem[pidx][bc][row_base.wr[SUBNET_B][bc]] <=
            {cmd_ff.b_tail, PAYLOAD_BITS'(cmd_ff.b_payload)};
      end
      if (state_ff == ST_SCAN) begin
         ent1_rd_ff <= store1_mem[pidx][c_sel][row_ff.rd[SUBNET_B][c_sel]];
      end
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.out_valid   = rsp_ff.out_valid;
   assign rsp_ch.out_subnet  = rsp_ff.out_subnet;
   assign rsp_ch.out_chan    = rsp_ff.out_chan;
   assign rsp_ch.out_tail    = rsp_ff.out_tail;
   assign rsp_ch.out_payload = rsp_ff.out_payload;
   assign rsp_ch.dropped     = rsp_ff.dropped;

endmodule

// ===== hw/rtl/packet_round_robin_output_merger.sv =====
`timescale 1ns / 1ps
// Merges flits of two subnetworks into per-port, per-subnet, per-channel FIFOs
// and pops at most one flit per step in packet-level round-robin order.
// req_ch: one step per beat (port, flit from subnet zero, flit from subnet one).
// rsp_ch: one result beat per request beat, in order: the delivered flit (if any),
//   the subnet where the scan stopped for credit return, and the dropped flags.
// csr_ch: writes active_vcs; write only while no step is in flight.
// The back end handles one step at a time: it takes no new step until the read-modify-write
//   of the port's state row (read, enqueue, scan and dequeue, write back) is done.
// A front register and a 2-deep command queue let requests keep arriving
//   while the back end works; up to 3 steps wait ahead of the back end.
// Reset: all FIFOs empty, every port's pointer at subnet 0 channel 0,
//   active_vcs = 8. Per-port valid bits clear the state at once; no sweep.
// Receiver stall: the result register holds, the back end waits in its last
//   step, the queue fills, and then req_ch.ready drops.
module packet_round_robin_output_merger #(
   parameter int PORTS        = prom_pkg::DEF_PORTS,
   parameter int MAX_VCS      = prom_pkg::DEF_MAX_VCS,
   parameter int QUEUE_DEPTH  = prom_pkg::DEF_QUEUE_DEPTH,
   parameter int PAYLOAD_BITS = prom_pkg::DEF_PAYLOAD_BITS
) (
   input  logic       clock,
   input  logic       reset,
   prom_req_if.sink   req_ch,
   prom_rsp_if.source rsp_ch,
   prom_csr_if.sink   csr_ch
);
   import prom_pkg::*;

`include "packet_round_robin_output_merger_assert.svh"

   localparam int NVC_W = $clog2(MAX_VCS + 1);

   logic [CFG_W-1:0]     active_vcs_ff, active_vcs_in;
   logic [NVC_W-1:0]     nvc;
   cmd_beat_type         push_beat, pop_beat;
   logic                 push_ready, pop, front_busy;
   logic [CMD_CNT_W-1:0] fifo_level;

   assign csr_ch.ready  = 1'b1;
   assign active_vcs_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : active_vcs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_vcs_ff <= ACTIVE_VCS_RESET;
      end else begin
         active_vcs_ff <= active_vcs_in;
      end
   end

   // clamp: zero acts as one, above MAX_VCS acts as MAX_VCS
   always_comb begin
      if (active_vcs_ff == '0) begin
         nvc = NVC_W'(1);
      end else if (32'(active_vcs_ff) > 32'(MAX_VCS)) begin
         nvc = NVC_W'(MAX_VCS);
      end else begin
         nvc = NVC_W'(active_vcs_ff);
      end
   end

   prom_front #(
      .PORTS   (PORTS),
      .MAX_VCS (MAX_VCS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .nvc        (nvc),
      .req_ch     (req_ch),
      .push_beat  (push_beat),
      .push_ready (push_ready),
      .busy       (front_busy)
   );

   prom_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_beat  (push_beat),
      .push_ready (push_ready),
      .pop_beat   (pop_beat),
      .pop        (pop),
      .level      (fifo_level)
   );

   prom_back #(
      .PORTS        (PORTS),
      .MAX_VCS      (MAX_VCS),
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .nvc      (nvc),
      .pop_beat (pop_beat),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

   `PROM_ASSERT_IMPLY(a_empty_rsp_zero, clock, reset, rsp_ch.valid && !rsp_ch.out_valid, rsp_ch.out_chan == '0 && !rsp_ch.out_tail && rsp_ch.out_payload == '0)
   `PROM_ASSERT_NEXT(a_accept_held, clock, reset, req_ch.valid && req_ch.ready, front_busy)
   `PROM_ASSERT_IMPLY(a_fifo_bound, clock, reset, 1'b1, 32'(fifo_level) <= 32'(CMD_FIFO_DEPTH))

endmodule

// ===== tb/sv/tb_packet_round_robin_output_merger.sv =====
`timescale 1ns / 1ps
module tb_packet_round_robin_output_merger;
   import prom_pkg::*;

   localparam int PORTS = DEF_PORTS;
   localparam int MAX_VCS = DEF_MAX_VCS;
   localparam int DEPTH = DEF_QUEUE_DEPTH;
   localparam int NQ = PORTS * 2 * MAX_VCS;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic              a_valid;
      logic [CHAN_W-1:0] a_chan;
      logic              a_tail;
      logic [DATA_W-1:0] a_payload;
      logic              b_valid;
      logic [CHAN_W-1:0] b_chan;
      logic              b_tail;
      logic [DATA_W-1:0] b_payload;
   } merge_step_type;

   logic clock;
   logic reset;

   prom_req_if req_if ();
   prom_rsp_if rsp_if ();
   prom_csr_if csr_if ();

   packet_round_robin_output_merger dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // merger state as the testbench sees it
   logic [DATA_W-1:0] fifo_payload [NQ*DEPTH];
   logic              fifo_tail    [NQ*DEPTH];
   int                fifo_count   [NQ];
   int                fifo_rd      [NQ];
   int                fifo_wr      [NQ];
   logic              rr_subnet    [PORTS];
   int                rr_chan      [PORTS];
   logic [CFG_W-1:0]  vcs_reg;

   merge_step_type steps_pending [$];
   rsp_type        flit_results_due [$];
   merge_step_type step_on_bus;
   bit             req_taken;
   int             mismatch_count;

   // packet generator state per port and subnet
   int pkt_chan [PORTS][2];
   int pkt_left [PORTS][2];

   int burst_left, gap_left;
   int stall_mode, mode_left, stall_left;

   function automatic int eff_vcs(input logic [CFG_W-1:0] cfg);
      if (cfg == 0) return 1;
      if (cfg > MAX_VCS) return MAX_VCS;
      return int'(cfg);
   endfunction

   // append one flit; return 1 when it was dropped
   function automatic bit enqueue_flit(input int port, input int subnet,
                                       input logic [CHAN_W-1:0] chan, input logic tail,
                                       input logic [DATA_W-1:0] payload, input int nvc);
      int q, slot;
      if (int'(chan) >= nvc) return 1;
      q = (port * 2 + subnet) * MAX_VCS + int'(chan);
      if (fifo_count[q] >= DEPTH) return 1;
      slot = q * DEPTH + fifo_wr[q];
      fifo_payload[slot] = payload;
      fifo_tail[slot] = tail;
      fifo_wr[q] = (fifo_wr[q] + 1) % DEPTH;
      fifo_count[q]++;
      return 0;
   endfunction

   function automatic rsp_type merge_step(input merge_step_type st);
      rsp_type r;
      int nvc, p, start, pos, q, slot, i;
      bit hit;
      r = '0;
      nvc = eff_vcs(vcs_reg);
      if (int'(st.port) >= PORTS) begin
         r.dropped = {st.b_valid, st.a_valid};
         return r;
      end
      p = int'(st.port);
      if (st.a_valid && enqueue_flit(p, 0, st.a_chan, st.a_tail, st.a_payload, nvc))
         r.dropped[DROP_A] = 1'b1;
      if (st.b_valid && enqueue_flit(p, 1, st.b_chan, st.b_tail, st.b_payload, nvc))
         r.dropped[DROP_B] = 1'b1;
      // scan position encoded as chan*2 + subnet, so advancing is +1 with wrap
      start = rr_chan[p] * 2 + int'(rr_subnet[p]);
      if (rr_chan[p] >= nvc) start = 0;
      pos = start;
      hit = 0;
      for (i = 0; i < 2 * nvc && !hit; i++) begin
         q = (p * 2 + pos % 2) * MAX_VCS + pos / 2;
         if (fifo_count[q] != 0) hit = 1;
         else pos = (pos + 1) % (2 * nvc);
      end
      if (!hit) pos = start;
      r.out_subnet = pos[0];
      if (hit) begin
         q = (p * 2 + pos % 2) * MAX_VCS + pos / 2;
         slot = q * DEPTH + fifo_rd[q];
         r.out_valid = 1'b1;
         r.out_chan = CHAN_W'(pos / 2);
         r.out_tail = fifo_tail[slot];
         r.out_payload = fifo_payload[slot];
         fifo_rd[q] = (fifo_rd[q] + 1) % DEPTH;
         fifo_count[q]--;
         // move on only once the packet has ended
         if (fifo_tail[slot]) pos = (pos + 1) % (2 * nvc);
      end
      rr_subnet[p] = pos[0];
      rr_chan[p] = pos / 2;
      return r;
   endfunction

   function automatic merge_step_type make_step(input int port,
                                                input bit av, input int ac, input bit at,
                                                input logic [DATA_W-1:0] ap,
                                                input bit bv, input int bc, input bit bt,
                                                input logic [DATA_W-1:0] bp);
      merge_step_type st;
      st.port = PORT_W'(port);
      st.a_valid = av;
      st.a_chan = CHAN_W'(ac);
      st.a_tail = at;
      st.a_payload = ap;
      st.b_valid = bv;
      st.b_chan = CHAN_W'(bc);
      st.b_tail = bt;
      st.b_payload = bp;
      return st;
   endfunction

   task automatic queue_random_steps(input int n, input logic [CFG_W-1:0] cfg,
                                     input int load);
      merge_step_type st;
      bit          v [2];
      int          ch [2];
      bit          tl [2];
      logic [DATA_W-1:0] pl [2];
      int i, s, p, lim;
      lim = eff_vcs(cfg);
      for (i = 0; i < n; i++) begin
         p = $urandom_range(0, PORTS - 1);
         for (s = 0; s < 2; s++) begin
            v[s] = ($urandom_range(0, 99) < load);
            pl[s] = $urandom;
            if ($urandom_range(0, 9) == 0) begin
               // noise: any channel, any tail
               ch[s] = $urandom_range(0, 7);
               tl[s] = $urandom_range(0, 1);
            end else begin
               if (pkt_left[p][s] == 0) begin
                  pkt_chan[p][s] = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 7)
                                                                : $urandom_range(0, lim - 1);
                  pkt_left[p][s] = $urandom_range(1, 5);
               end
               ch[s] = pkt_chan[p][s];
               tl[s] = (pkt_left[p][s] == 1);
               if (v[s]) pkt_left[p][s]--;
            end
         end
         st = make_step(p, v[0], ch[0], tl[0], pl[0], v[1], ch[1], tl[1], pl[1]);
         steps_pending.push_back(st);
      end
   endtask

   task automatic wait_drained();
      while (steps_pending.size() != 0 || req_if.valid || flit_results_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_active_vcs(input logic [CFG_W-1:0] val);
      wait_drained();
      repeat (6) @(posedge clock);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.data = val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      vcs_reg = val;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   always #6 clock = ~clock;

   // request side: note accepted beats and predict their results
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         flit_results_due.push_back(merge_step(step_on_bus));
         req_taken = 1;
      end
   end

   // driver: bursts with random gaps; hold the beat until taken
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid = 1'b0;
      end else if (!req_if.valid || req_taken) begin
         req_taken = 0;
         if (burst_left == 0 && gap_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid = 1'b0;
         end else if (steps_pending.size() != 0) begin
            step_on_bus = steps_pending.pop_front();
            req_if.port = step_on_bus.port;
            req_if.a_valid = step_on_bus.a_valid;
            req_if.a_chan = step_on_bus.a_chan;
            req_if.a_tail = step_on_bus.a_tail;
            req_if.a_payload = step_on_bus.a_payload;
            req_if.b_valid = step_on_bus.b_valid;
            req_if.b_chan = step_on_bus.b_chan;
            req_if.b_tail = step_on_bus.b_tail;
            req_if.b_payload = step_on_bus.b_payload;
            req_if.valid = 1'b1;
            if (burst_left > 0) burst_left--;
         end else begin
            req_if.valid = 1'b0;
         end
      end
   end

   // receiver: stall pattern switches between modes every so often
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (stall_mode)
         0: rsp_if.ready = 1'b1;
         1: rsp_if.ready = $urandom_range(0, 1);
         2: rsp_if.ready = (mode_left % 3 == 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_if.ready = 1'b0;
            end else begin
               rsp_if.ready = 1'b1;
               if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
            end
         end
      endcase
   end

   // monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.out_valid = rsp_if.out_valid;
         got.out_subnet = rsp_if.out_subnet;
         got.out_chan = rsp_if.out_chan;
         got.out_tail = rsp_if.out_tail;
         got.out_payload = rsp_if.out_payload;
         got.dropped = rsp_if.dropped;
         if (flit_results_due.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result beat: v=%0d s=%0d ch=%0d t=%0d pl=%h dr=%0d",
                        got.out_valid, got.out_subnet, got.out_chan, got.out_tail,
                        got.out_payload, got.dropped);
            mismatch_count++;
         end else begin
            want = flit_results_due.pop_front();
            if (got.out_valid !== want.out_valid || got.out_subnet !== want.out_subnet ||
                got.out_chan !== want.out_chan || got.out_tail !== want.out_tail ||
                got.out_payload !== want.out_payload || got.dropped !== want.dropped) begin
               if (mismatch_count < 10) begin
                  $display("result mismatch: exp v=%0d s=%0d ch=%0d t=%0d pl=%h dr=%0d",
                           want.out_valid, want.out_subnet, want.out_chan, want.out_tail,
                           want.out_payload, want.dropped);
                  $display("                 got v=%0d s=%0d ch=%0d t=%0d pl=%h dr=%0d",
                           got.out_valid, got.out_subnet, got.out_chan, got.out_tail,
                           got.out_payload, got.dropped);
               end
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #6_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [CFG_W-1:0] settings [8];
      int loads [8];
      int i, k;
      settings = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd8};
      loads = '{45, 70, 30, 55, 75, 40, 65, 50};
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.port = '0;
      req_if.a_valid = 1'b0;
      req_if.a_chan = '0;
      req_if.a_tail = 1'b0;
      req_if.a_payload = '0;
      req_if.b_valid = 1'b0;
      req_if.b_chan = '0;
      req_if.b_tail = 1'b0;
      req_if.b_payload = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      for (i = 0; i < NQ * DEPTH; i++) begin
         fifo_payload[i] = '0;
         fifo_tail[i] = 1'b0;
      end
      for (i = 0; i < NQ; i++) begin
         fifo_count[i] = 0;
         fifo_rd[i] = 0;
         fifo_wr[i] = 0;
      end
      for (i = 0; i < PORTS; i++) begin
         rr_subnet[i] = SUBNET_A;
         rr_chan[i] = 0;
         pkt_chan[i][0] = 0;
         pkt_chan[i][1] = 0;
         pkt_left[i][0] = 0;
         pkt_left[i][1] = 0;
      end
      vcs_reg = ACTIVE_VCS_RESET;
      req_taken = 0;
      mismatch_count = 0;
      burst_left = 0;
      gap_left = 0;
      stall_mode = 0;
      mode_left = 0;
      stall_left = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < 8; k++) begin
         write_active_vcs(settings[k]);
         if (k == 0) begin
            // empty scan, payload and channel extremes
            steps_pending.push_back(make_step(3, 0, 0, 0, '0, 0, 0, 0, '0));
            steps_pending.push_back(make_step(0, 1, 0, 0, 32'h0000_0000,
                                              1, 7, 1, 32'hffff_ffff));
            steps_pending.push_back(make_step(0, 1, 7, 1, 32'hffff_ffff,
                                              1, 0, 0, 32'h0000_0000));
            steps_pending.push_back(make_step(0, 0, 0, 0, '0, 0, 0, 0, '0));
            // pointer rests on subnet zero, so subnet one fills up and then drops
            for (i = 0; i < 18; i++)
               steps_pending.push_back(make_step(1, 1, 0, 0, $urandom, 1, 0, 0, $urandom));
            steps_pending.push_back(make_step(1, 1, 0, 1, $urandom, 0, 0, 0, '0));
            steps_pending.push_back(make_step(1, 0, 0, 0, '0, 0, 0, 0, '0));
         end else if (k == 2) begin
            // channels beyond the active count, pointers possibly past it too
            steps_pending.push_back(make_step(2, 1, 5, 1, $urandom, 1, 3, 1, $urandom));
            steps_pending.push_back(make_step(0, 1, 2, 1, $urandom, 1, 7, 0, $urandom));
         end
         queue_random_steps(170, settings[k], loads[k]);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && flit_results_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/prom_pkg.sv
hw/rtl/prom_channels.sv
hw/rtl/prom_front.sv
hw/rtl/prom_cmd_fifo.sv
hw/rtl/prom_back.sv
hw/rtl/packet_round_robin_output_merger.sv
tb/sv/tb_packet_round_robin_output_merger.sv
